// ----- src/terminal_cursor_tabstop_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// Cursor and tab stop engine assertion macros
// Concurrent assertion helpers used by the engine top level.
// ----------------------------------------------------------------------------
`ifndef TERMINAL_CURSOR_TABSTOP_ENGINE_TOP_MACROS_SVH
`define TERMINAL_CURSOR_TABSTOP_ENGINE_TOP_MACROS_SVH

`ifndef SYNTH
`define TCTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TCTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- src/tcte_pkg.sv -----
// ----------------------------------------------------------------------------
// Cursor and tab stop engine package
// Command codes, sizes and defaults used by the engine top level.
// ----------------------------------------------------------------------------
package tcte_pkg;

  localparam int MAX_COLS_DEF     = 256;
  localparam int TAB_INTERVAL_DEF = 8;
  localparam int WORD_BITS        = 16;
  localparam int CFG_DATA_W       = 9;
  localparam int CFG_ADDR_W       = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 1'd1;

  localparam logic [3:0] CMD_RESET      = 4'd0;
  localparam logic [3:0] CMD_UP         = 4'd1;
  localparam logic [3:0] CMD_DOWN       = 4'd2;
  localparam logic [3:0] CMD_FWD        = 4'd3;
  localparam logic [3:0] CMD_BACK       = 4'd4;
  localparam logic [3:0] CMD_SETPOS     = 4'd5;
  localparam logic [3:0] CMD_SETPOS_ORG = 4'd6;
  localparam logic [3:0] CMD_NEXTLINE   = 4'd7;
  localparam logic [3:0] CMD_CLAMP      = 4'd8;
  localparam logic [3:0] CMD_SETREGION  = 4'd9;
  localparam logic [3:0] CMD_CLRREGION  = 4'd10;
  localparam logic [3:0] CMD_NEXTTAB    = 4'd11;
  localparam logic [3:0] CMD_PREVTAB    = 4'd12;
  localparam logic [3:0] CMD_SETTAB     = 4'd13;
  localparam logic [3:0] CMD_CLRTAB     = 4'd14;
  localparam logic [3:0] CMD_CLRALLTABS = 4'd15;

endpackage

// ----- src/tcte_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcte_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/terminal_cursor_tabstop_engine_top.sv -----
// Cursor and region commands run in the execute state; the done state registers their result.
// Tab set and clear below the marked length do one stop store read, then one write back.
// Tab queries read 0..16 words of 16 stops from the stop store.
// One command at a time: a word is taken only in the idle state, even while a result still waits.
// Reset is synchronous: cursor home, region cleared, registers 80 columns and 24 rows,
// stops at every TAB_INTERVAL column through per-word valid bits, no clearing pass.
// ----------------------------------------------------------------------------
// Cursor and tab stop engine top level
// Cursor, scroll region and tab stop store with a word-wide stop search.
// ----------------------------------------------------------------------------
`include "terminal_cursor_tabstop_engine_top_macros.svh"

module terminal_cursor_tabstop_engine_top #(
  parameter int MAX_COLS     = tcte_pkg::MAX_COLS_DEF,
  parameter int TAB_INTERVAL = tcte_pkg::TAB_INTERVAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tcte_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tcte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0]                      in_cmd,
  input  logic [7:0]                      in_count,
  input  logic [7:0]                      in_row_arg,
  input  logic [7:0]                      in_col_arg,
  input  logic [7:0]                      in_bottom_arg,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_cursor_row,
  output logic [7:0]                      out_cursor_col,
  output logic [7:0]                      out_tab_col,
  output logic                            out_moved
);

  import tcte_pkg::*;

  localparam int COL_SPAN  = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int NUM_WORDS = (COL_SPAN + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int DEPTH     = 1 << AW;
  localparam logic [8:0] COL_SPAN_V = 9'(COL_SPAN);
  localparam logic [8:0] MARK_LEN_RST = (COL_SPAN < 80) ? 9'(COL_SPAN) : 9'd80;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [8:0] num_cols_r, num_rows_r;
  logic [8:0] mark_len_r, mark_len_nxt;
  logic [7:0] cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [7:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [7:0] tab_r, tab_nxt;
  logic       moved_r, moved_nxt;
  logic       pat_mode_r, pat_mode_nxt;
  logic [DEPTH-1:0] vld_r, vld_nxt;
  logic [AW-1:0] chk_w_r, chk_w_nxt;
  logic [8:0] scan_col_r, scan_col_nxt;
  logic [AW-1:0] end_w_r, end_w_nxt;
  logic [3:0] cmd_r;
  logic [7:0] count_r, row_arg_r, col_arg_r, bot_arg_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] o_row_r, o_col_r, o_tab_r;
  logic       o_moved_r;

  logic [WORD_BITS-1:0] pat_w [DEPTH];
  logic [WORD_BITS-1:0] ram_rdata, ram_wdata, eff_word;
  logic                 ram_we;

  logic [8:0] cols, rows, cols_m1, rows_m1;
  logic [7:0] eff_bot;
  logic [8:0] base_col, s_next, col_b;
  logic [WORD_BITS-1:0] hit;
  logic [3:0] hit_pos;
  logic       found;
  logic [8:0] sum9;
  logic [8:0] lim9;
  logic [AW-1:0] cur_w;

  genvar gw, gb;
  generate
    for (gw = 0; gw < DEPTH; gw++) begin : g_pat_w
      for (gb = 0; gb < WORD_BITS; gb++) begin : g_pat_b
        localparam int C = gw * WORD_BITS + gb;
        assign pat_w[gw][gb] = (C != 0) && ((C % TAB_INTERVAL) == 0) && (C < MAX_COLS);
      end
    end
  endgenerate

  tcte_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_stops (
    .clk  (clk),
    .we   (ram_we),
    .waddr(chk_w_r),
    .wdata(ram_wdata),
    .raddr(chk_w_nxt),
    .rdata(ram_rdata)
  );

  assign cols    = (num_cols_r == 9'd0) ? 9'd1 :
                   ((num_cols_r > COL_SPAN_V) ? COL_SPAN_V : num_cols_r);
  assign rows    = (num_rows_r == 9'd0) ? 9'd1 :
                   ((num_rows_r > 9'd256) ? 9'd256 : num_rows_r);
  assign cols_m1 = cols - 9'd1;
  assign rows_m1 = rows - 9'd1;
  assign eff_bot = (bot_r != 8'd0) ? bot_r : rows_m1[7:0];
  assign cur_w   = cur_col_r[4 +: AW];

  assign eff_word = vld_r[chk_w_r] ? ram_rdata :
                    (pat_mode_r ? pat_w[chk_w_r] : '0);
  assign base_col = 9'(chk_w_r) << 4;
  assign s_next   = 9'(cur_col_r) + 9'd1;

  always_comb begin
    hit     = '0;
    hit_pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      col_b = base_col + 9'(b);
      if (cmd_r == CMD_NEXTTAB) begin
        hit[b] = eff_word[b] && (col_b >= scan_col_r) && (col_b < cols) &&
                 (col_b < mark_len_r);
      end else begin
        hit[b] = eff_word[b] && (col_b <= scan_col_r) && (col_b != 9'd0) &&
                 (col_b < mark_len_r);
      end
    end
    if (cmd_r == CMD_NEXTTAB) begin
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
        if (hit[b]) hit_pos = 4'(b);
      end
    end else begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (hit[b]) hit_pos = 4'(b);
      end
    end
    found = |hit;
  end

  assign ram_we    = (state_r == S_MOD);
  assign ram_wdata = (cmd_r == CMD_SETTAB) ? (eff_word | (16'd1 << cur_col_r[3:0])) :
                                             (eff_word & ~(16'd1 << cur_col_r[3:0]));

  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    tab_nxt       = tab_r;
    moved_nxt     = moved_r;
    mark_len_nxt  = mark_len_r;
    pat_mode_nxt  = pat_mode_r;
    vld_nxt       = vld_r;
    chk_w_nxt     = chk_w_r;
    scan_col_nxt  = scan_col_r;
    end_w_nxt     = end_w_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sum9          = '0;
    lim9          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        tab_nxt   = 8'd0;
        moved_nxt = 1'b0;
        state_nxt = S_DONE;
        unique case (cmd_r) inside
          CMD_RESET: begin
            cur_row_nxt  = 8'd0;
            cur_col_nxt  = 8'd0;
            top_nxt      = 8'd0;
            bot_nxt      = 8'd0;
            mark_len_nxt = cols;
            pat_mode_nxt = 1'b1;
            vld_nxt      = '0;
          end
          CMD_UP: begin
            lim9 = ((cur_row_r >= top_r) && (cur_row_r <= eff_bot)) ? 9'(top_r) : 9'd0;
            sum9 = 9'(count_r) + lim9;
            cur_row_nxt = (9'(cur_row_r) > sum9) ? (cur_row_r - count_r) : lim9[7:0];
          end
          CMD_DOWN: begin
            sum9 = 9'(cur_row_r) + 9'(count_r);
            cur_row_nxt = (sum9 < 9'(bot_arg_r)) ? sum9[7:0] : bot_arg_r;
          end
          CMD_FWD: begin
            sum9 = 9'(cur_col_r) + 9'(count_r);
            cur_col_nxt = (sum9 < cols_m1) ? sum9[7:0] : cols_m1[7:0];
          end
          CMD_BACK: begin
            cur_col_nxt = (cur_col_r > count_r) ? (cur_col_r - count_r) : 8'd0;
          end
          CMD_SETPOS: begin
            cur_row_nxt = (9'(row_arg_r) < rows_m1) ? row_arg_r : rows_m1[7:0];
            cur_col_nxt = (9'(col_arg_r) < cols_m1) ? col_arg_r : cols_m1[7:0];
          end
          CMD_SETPOS_ORG: begin
            sum9 = 9'(row_arg_r) + 9'(top_r);
            cur_row_nxt = (sum9 < 9'(eff_bot)) ? sum9[7:0] : eff_bot;
            cur_col_nxt = (9'(col_arg_r) < cols_m1) ? col_arg_r : cols_m1[7:0];
          end
          CMD_NEXTLINE: begin
            sum9 = 9'(cur_row_r) + 9'd1;
            if (cur_row_r < bot_arg_r) begin
              cur_row_nxt = sum9[7:0];
              moved_nxt   = 1'b1;
            end else if (cur_row_r > bot_arg_r) begin
              cur_row_nxt = (sum9 < rows_m1) ? sum9[7:0] : rows_m1[7:0];
              moved_nxt   = 1'b1;
            end
          end
          CMD_CLAMP: begin
            cur_row_nxt = (9'(cur_row_r) < rows_m1) ? cur_row_r : rows_m1[7:0];
            cur_col_nxt = (9'(cur_col_r) < cols_m1) ? cur_col_r : cols_m1[7:0];
          end
          CMD_SETREGION: begin
            top_nxt = row_arg_r;
            bot_nxt = bot_arg_r;
          end
          CMD_CLRREGION: begin
            top_nxt = 8'd0;
            bot_nxt = 8'd0;
          end
          CMD_NEXTTAB: begin
            if (s_next >= cols) begin
              tab_nxt = cols_m1[7:0];
            end else begin
              scan_col_nxt = s_next;
              chk_w_nxt    = s_next[4 +: AW];
              end_w_nxt    = cols_m1[4 +: AW];
              state_nxt    = S_CHK;
            end
          end
          CMD_PREVTAB: begin
            if (cur_col_r > 8'd1) begin
              lim9 = 9'(cur_col_r) - 9'd1;
              scan_col_nxt = (lim9 < COL_SPAN_V) ? lim9 : (COL_SPAN_V - 9'd1);
              chk_w_nxt    = scan_col_nxt[4 +: AW];
              end_w_nxt    = '0;
              state_nxt    = S_CHK;
            end
          end
          CMD_SETTAB, CMD_CLRTAB: begin
            if (9'(cur_col_r) < mark_len_r) begin
              chk_w_nxt = cur_w;
              state_nxt = S_MOD;
            end
          end
          default: begin
            pat_mode_nxt = 1'b0;
            vld_nxt      = '0;
          end
        endcase
      end
      S_CHK: begin
        if (found) begin
          tab_nxt   = base_col[7:0] + 8'(hit_pos);
          state_nxt = S_DONE;
        end else if (chk_w_r == end_w_r) begin
          tab_nxt   = (cmd_r == CMD_NEXTTAB) ? cols_m1[7:0] : 8'd0;
          state_nxt = S_DONE;
        end else begin
          chk_w_nxt = (cmd_r == CMD_NEXTTAB) ? (chk_w_r + AW'(1)) : (chk_w_r - AW'(1));
        end
      end
      S_MOD: begin
        vld_nxt[chk_w_r] = 1'b1;
        state_nxt        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_cols_r  <= 9'd80;
      num_rows_r  <= 9'd24;
      mark_len_r  <= MARK_LEN_RST;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      bot_r       <= '0;
      tab_r       <= '0;
      moved_r     <= 1'b0;
      pat_mode_r  <= 1'b1;
      vld_r       <= '0;
      chk_w_r     <= '0;
      scan_col_r  <= '0;
      end_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mark_len_r  <= mark_len_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      bot_r       <= bot_nxt;
      tab_r       <= tab_nxt;
      moved_r     <= moved_nxt;
      pat_mode_r  <= pat_mode_nxt;
      vld_r       <= vld_nxt;
      chk_w_r     <= chk_w_nxt;
      scan_col_r  <= scan_col_nxt;
      end_w_r     <= end_w_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NUM_COLS: num_cols_r <= cfg_wdata;
          REG_NUM_ROWS: num_rows_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r     <= in_cmd;
      count_r   <= in_count;
      row_arg_r <= in_row_arg;
      col_arg_r <= in_col_arg;
      bot_arg_r <= in_bottom_arg;
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      o_row_r   <= cur_row_r;
      o_col_r   <= cur_col_r;
      o_tab_r   <= tab_r;
      o_moved_r <= moved_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_row = o_row_r;
  assign out_cursor_col = o_col_r;
  assign out_tab_col    = o_tab_r;
  assign out_moved      = o_moved_r;

  `TCTE_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC, "accepted word did not start execution")
  `TCTE_ASSERT_SAME(a_scan_cmd, clk, rst_n, state_r == S_CHK, cmd_r == CMD_NEXTTAB || cmd_r == CMD_PREVTAB, "stop scan for a non-query command")
  `TCTE_ASSERT_SAME(a_write_gated, clk, rst_n, ram_we, 9'(cur_col_r) < mark_len_r, "stop store write beyond the marked columns")

endmodule
